FILE: sv/utcal_pkg.sv
// ----------------------------------------------------------------------------
// utcal_pkg
// Shared types, constants, calendar tables and the sequencer microcode.
// ----------------------------------------------------------------------------
package utcal_pkg;

    localparam int UNIX_W   = 32;
    localparam int REM_W    = 33;   // local time can pass 2^32 with a positive offset
    localparam int CHUNK_W  = 25;   // widest chunk is a leap year in seconds
    localparam int OFF_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int WDAY_W   = 3;
    localparam int WEEK_W   = 3;
    localparam int PC_W     = 4;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 12'd1970;
    localparam logic [YEAR_W-1:0]  NONLEAP_CENTURY = 12'd2100;
    localparam logic [WDAY_W-1:0]  EPOCH_WDAY  = 3'd4;
    localparam logic [MONTH_W-1:0] MON_FEB     = 4'd1;
    localparam logic [MONTH_W-1:0] MON_MAR     = 4'd2;
    localparam logic [MONTH_W-1:0] MON_NOV     = 4'd10;
    localparam logic [MONTH_W-1:0] MON_DEC     = 4'd11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UTC_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_ENABLE = 1'd1;

    typedef logic [0:0]      op_t;
    typedef logic [2:0]      sel_t;
    typedef logic [PC_W-1:0] pc_t;

    localparam op_t OP_WALK = 1'b0;
    localparam op_t OP_DONE = 1'b1;

    localparam sel_t SEL_YEAR  = 3'd0;
    localparam sel_t SEL_MONTH = 3'd1;
    localparam sel_t SEL_DAY10 = 3'd2;
    localparam sel_t SEL_DAY1  = 3'd3;
    localparam sel_t SEL_HOUR10 = 3'd4;
    localparam sel_t SEL_HOUR1 = 3'd5;
    localparam sel_t SEL_MIN10 = 3'd6;
    localparam sel_t SEL_MIN1  = 3'd7;

    typedef struct packed {
        op_t  op;
        sel_t sel;
        pc_t  jmp;     // target when the chunk was taken
    } ucode_t;

    typedef struct packed {
        logic load;    // item accepted this cycle
        logic run;     // a microcode step executes this cycle
        op_t  op;
        sel_t sel;
    } ctrl_t;

    // Valid for 1970..2106 only: 2100 is the one non-leap century year in that span.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != NONLEAP_CENTURY);
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd0:    d = 5'd31;
            4'd1:    d = leap ? 5'd29 : 5'd28;
            4'd2:    d = 5'd31;
            4'd3:    d = 5'd30;
            4'd4:    d = 5'd31;
            4'd5:    d = 5'd30;
            4'd6:    d = 5'd31;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd30;
            4'd9:    d = 5'd31;
            4'd10:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic [CHUNK_W-1:0] month_secs(input logic [DAY_W-1:0] d);
        logic [CHUNK_W-1:0] s;
        unique case (d)
            5'd28:   s = 25'd2419200;
            5'd29:   s = 25'd2505600;
            5'd30:   s = 25'd2592000;
            default: s = 25'd2678400;
        endcase
        return s;
    endfunction

    function automatic logic [WEEK_W-1:0] week_index(input logic [DAY_W-1:0] d,
                                                     input logic [WDAY_W-1:0] first);
        logic [5:0] v;
        logic [WEEK_W-1:0] w;
        v = 6'(d) + 6'(first) + 6'd1;
        priority if (v >= 6'd35) w = 3'd5;
        else if (v >= 6'd28)     w = 3'd4;
        else if (v >= 6'd21)     w = 3'd3;
        else if (v >= 6'd14)     w = 3'd2;
        else if (v >= 6'd7)      w = 3'd1;
        else                     w = 3'd0;
        return w;
    endfunction

    // Microcode: each walk step repeats while its chunk is taken, then falls through.
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t u;
        unique case (pc)
            4'd0:    u = '{op: OP_WALK, sel: SEL_YEAR,   jmp: 4'd0};
            4'd1:    u = '{op: OP_WALK, sel: SEL_MONTH,  jmp: 4'd1};
            4'd2:    u = '{op: OP_WALK, sel: SEL_DAY10,  jmp: 4'd2};
            4'd3:    u = '{op: OP_WALK, sel: SEL_DAY1,   jmp: 4'd3};
            4'd4:    u = '{op: OP_WALK, sel: SEL_HOUR10, jmp: 4'd4};
            4'd5:    u = '{op: OP_WALK, sel: SEL_HOUR1,  jmp: 4'd5};
            4'd6:    u = '{op: OP_WALK, sel: SEL_MIN10,  jmp: 4'd6};
            4'd7:    u = '{op: OP_WALK, sel: SEL_MIN1,   jmp: 4'd7};
            default: u = '{op: OP_DONE, sel: SEL_YEAR,   jmp: 4'd0};
        endcase
        return u;
    endfunction

endpackage

FILE: sv/utcal_datapath.sv
// ----------------------------------------------------------------------------
// utcal_datapath
// Remainder register with one compare/subtract unit, calendar counters,
// weekday tracking and the daylight-saving decision.
// ----------------------------------------------------------------------------
module utcal_datapath
    import utcal_pkg::*;
(
    input  logic                clk,
    input  ctrl_t               ctrl,
    input  logic [OFF_W-1:0]    offset,
    input  logic                dst_en,
    input  logic [UNIX_W-1:0]   epoch_secs,
    output logic                take,
    output logic [YEAR_W-1:0]   year,
    output logic [MONTH_W-1:0]  month,
    output logic [DAY_W-1:0]    day,
    output logic [HOUR_W-1:0]   hour,
    output logic [MIN_W-1:0]    minute,
    output logic [SEC_W-1:0]    second,
    output logic [WDAY_W-1:0]   day_of_week,
    output logic [WDAY_W-1:0]   first_day_of_week,
    output logic [WEEK_W-1:0]   week_of_month,
    output logic                dst_active
);

    logic [REM_W-1:0]   rem_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [MIN_W-1:0]   min_reg;
    logic [WDAY_W-1:0]  wd_reg;
    logic [WDAY_W-1:0]  first_reg;

    logic signed [UNIX_W+1:0] local_s;
    logic [REM_W-1:0]   local_clamped;
    logic               leap;
    logic [DAY_W-1:0]   mdays;
    logic [CHUNK_W-1:0] chunk;
    logic [2:0]         wd_add;
    logic [3:0]         wd_sum;
    logic [WDAY_W-1:0]  wd_next;
    logic [REM_W-1:0]   rem_next;

    logic [WEEK_W-1:0]  week;
    logic [3:0]         sdow_sum;
    logic [WDAY_W-1:0]  sdow;
    logic [WDAY_W-1:0]  ssun;
    logic               dst;

    assign local_s = $signed({2'b00, epoch_secs})
                   + $signed({{(UNIX_W+2-OFF_W){offset[OFF_W-1]}}, offset})
                   * $signed(34'sd3600);
    assign local_clamped = local_s[UNIX_W+1] ? '0 : local_s[REM_W-1:0];

    assign leap  = is_leap(year_reg);
    assign mdays = month_days(month_reg, leap);

    always_comb
    begin
        chunk  = '0;
        wd_add = 3'd0;
        unique case (ctrl.sel)
            SEL_YEAR:
            begin
                chunk  = leap ? 25'd31622400 : 25'd31536000;
                wd_add = leap ? 3'd2 : 3'd1;
            end
            SEL_MONTH:
            begin
                chunk  = month_secs(mdays);
                wd_add = 3'(mdays - 5'd28);
            end
            SEL_DAY10:
            begin
                chunk  = 25'd864000;
                wd_add = 3'd3;
            end
            SEL_DAY1:
            begin
                chunk  = 25'd86400;
                wd_add = 3'd1;
            end
            SEL_HOUR10: chunk = 25'd36000;
            SEL_HOUR1:  chunk = 25'd3600;
            SEL_MIN10:  chunk = 25'd600;
            default:    chunk = 25'd60;
        endcase
    end

    // months stop at December whatever is left
    assign take = (rem_reg >= {{(REM_W-CHUNK_W){1'b0}}, chunk})
               && !(ctrl.sel == SEL_MONTH && month_reg == MON_DEC);
    assign rem_next = rem_reg - {{(REM_W-CHUNK_W){1'b0}}, chunk};
    assign wd_sum   = {1'b0, wd_reg} + {1'b0, wd_add};
    assign wd_next  = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[WDAY_W-1:0];

    // daylight-saving decision, on the finished fields
    assign week     = week_index(day_reg, first_reg);
    assign sdow_sum = {1'b0, wd_reg} + 4'd7 - {1'b0, first_reg};
    assign sdow     = (sdow_sum >= 4'd7) ? 3'(sdow_sum - 4'd7) : sdow_sum[WDAY_W-1:0];
    assign ssun     = (first_reg == 3'd0) ? 3'd0 : 3'(4'd7 - {1'b0, first_reg});

    always_comb
    begin
        dst = 1'b0;
        if (dst_en)
        begin
            priority if (month_reg > MON_MAR && month_reg < MON_NOV)
                dst = 1'b1;
            else if (month_reg == MON_MAR && week > 3'd2)
                dst = 1'b1;
            else if (month_reg == MON_MAR && week == 3'd2)
                dst = (sdow > ssun) || (sdow == ssun && hour_reg >= 5'd2);
            else if (month_reg == MON_NOV && week == 3'd1)
                dst = (sdow < ssun) || (sdow == ssun && hour_reg < 5'd1);
            else
                dst = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg   <= local_clamped;
            year_reg  <= EPOCH_YEAR;
            month_reg <= '0;
            day_reg   <= 5'd1;
            hour_reg  <= '0;
            min_reg   <= '0;
            wd_reg    <= EPOCH_WDAY;
        end
        else if (ctrl.run && ctrl.op == OP_WALK)
        begin
            if (take)
            begin
                rem_reg <= rem_next;
                wd_reg  <= wd_next;
                unique case (ctrl.sel)
                    SEL_YEAR:   year_reg  <= year_reg + 12'd1;
                    SEL_MONTH:  month_reg <= month_reg + 4'd1;
                    SEL_DAY10:  day_reg   <= day_reg + 5'd10;
                    SEL_DAY1:   day_reg   <= day_reg + 5'd1;
                    SEL_HOUR10: hour_reg  <= hour_reg + 5'd10;
                    SEL_HOUR1:  hour_reg  <= hour_reg + 5'd1;
                    SEL_MIN10:  min_reg   <= min_reg + 6'd10;
                    default:    min_reg   <= min_reg + 6'd1;
                endcase
            end
            else if (ctrl.sel == SEL_MONTH)
            begin
                first_reg <= wd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.run && ctrl.op == OP_DONE)
        begin
            year              <= year_reg;
            month             <= month_reg;
            day               <= day_reg;
            hour              <= hour_reg + {4'd0, dst};
            minute            <= min_reg;
            second            <= rem_reg[SEC_W-1:0];
            day_of_week       <= wd_reg;
            first_day_of_week <= first_reg;
            week_of_month     <= week;
            dst_active        <= dst;
        end
    end

endmodule

FILE: sv/unix_time_to_calendar_dst_core.sv
// ----------------------------------------------------------------------------
// unix_time_to_calendar_dst_core
// Unix seconds to local calendar date and time with US daylight saving.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with epoch_secs while busy is low; the item is taken on that
//   edge and busy rises. A microcoded sequencer walks years, months, tens of
//   days, days, tens of hours, hours, tens of minutes and minutes with one
//   shared compare/subtract unit, one chunk per cycle. When the walk ends the
//   fields are registered and done is high for exactly one cycle; the fields
//   then hold until the next item finishes.
//   One item is in flight at a time; the next start is taken in the cycle
//   done is high. The year walk takes the most steps of the walk.
//   Configuration: wr_en with wr_index selects utc_offset_hours (index 0,
//   signed 5 bits) or dst_enable (index 1), write only while busy is low.
//   Reset clears the sequencer and both registers (offset 0, no DST).
//   done cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module unix_time_to_calendar_dst_core
    import utcal_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [UNIX_W-1:0]     epoch_secs,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [OFF_W-1:0]      wr_data,
    output logic                  done,
    output logic [YEAR_W-1:0]     year,
    output logic [MONTH_W-1:0]    month,
    output logic [DAY_W-1:0]      day,
    output logic [HOUR_W-1:0]     hour,
    output logic [MIN_W-1:0]      minute,
    output logic [SEC_W-1:0]      second,
    output logic [WDAY_W-1:0]     day_of_week,
    output logic [WDAY_W-1:0]     first_day_of_week,
    output logic [WEEK_W-1:0]     week_of_month,
    output logic                  dst_active
);

    logic             busy_reg;
    logic             done_reg;
    pc_t              pc_reg;
    pc_t              pc_next;
    logic [OFF_W-1:0] offset_reg;
    logic             dst_en_reg;

    ucode_t uword;
    ctrl_t  ctrl;
    logic   accept;
    logic   take;

    assign accept = start && !busy_reg;
    assign uword  = ucode_rom(pc_reg);

    assign ctrl.load = accept;
    assign ctrl.run  = busy_reg;
    assign ctrl.op   = uword.op;
    assign ctrl.sel  = uword.sel;

    assign pc_next = take ? uword.jmp : pc_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            done_reg <= busy_reg && uword.op == OP_DONE;
            if (accept)
            begin
                busy_reg <= 1'b1;
                pc_reg   <= '0;
            end
            else if (busy_reg)
            begin
                if (uword.op == OP_DONE)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    pc_reg <= pc_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            dst_en_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_UTC_OFFSET: offset_reg <= wr_data;
                default:        dst_en_reg <= wr_data[0];
            endcase
        end
    end

    utcal_datapath u_datapath (
        .clk               (clk),
        .ctrl              (ctrl),
        .offset            (offset_reg),
        .dst_en            (dst_en_reg),
        .epoch_secs        (epoch_secs),
        .take              (take),
        .year              (year),
        .month             (month),
        .day               (day),
        .hour              (hour),
        .minute            (minute),
        .second            (second),
        .day_of_week       (day_of_week),
        .first_day_of_week (first_day_of_week),
        .week_of_month     (week_of_month),
        .dst_active        (dst_active)
    );

    assign busy = busy_reg;
    assign done = done_reg;

endmodule
